// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the downsampler checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define RPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpd assertion failed");

// Next-cycle implication, clocked on the rising edge, off during reset.
`define RPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpd assertion failed");

`endif

// ===== src/rpd_pkg.sv =====
// ---------------------------------------------------------------------------
// rpd_pkg
// Types, constants and control structs of the 2x2 RMS pixel downsampler.
// ---------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int WIDTH_W           = 13;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd256;
   localparam int ROW_W             = 12;
   localparam int COORD_W           = 11;
   localparam int CHAN_W            = 8;
   localparam int RGB_W             = 24;
   localparam int PAIR_W            = 48;
   localparam int SQ_W              = 16;
   localparam int SUM_W             = 18;
   localparam int ROOT_W            = 9;
   localparam int REM_W             = 10;
   localparam int NUM_CHAN          = 3;
   localparam int SQRT_STEPS        = 9;
   localparam int STEP_W            = 4;
   localparam logic [CHAN_W-1:0] ALPHA = 8'hFF;

   typedef struct packed {
      logic [31:0] in_pixel;
      logic        frame_start;
   } req_type;

   typedef struct packed {
      logic [31:0]        out_pixel;
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic square;
      logic load_root;
      logic step_root;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic emit_item;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== src/rms_2x2_pixel_downsampler.sv =====
// Pixel at an even column, or at an odd column of an even row: taken without a stall, no result.
// Pixel at an odd column of an odd row: the sequencer runs square, sum, the root steps and done,
// and the next pixel is taken once done hands the result to a free output register;
// the root phase runs the 9 steps of the square-root unit.
// Reset is synchronous: width 256, position and left pixel zero, no result pending.
// The line buffer is not cleared; each entry is written on an even row before use.
// ---------------------------------------------------------------------------
// rms_2x2_pixel_downsampler
// Builds the next mipmap level from a raster ARGB stream with a 2x2 RMS filter.
// ---------------------------------------------------------------------------
`default_nettype none

module rms_2x2_pixel_downsampler #(
   parameter int MAX_WIDTH = rpd_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire rpd_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output rpd_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [rpd_pkg::WIDTH_W-1:0]  csr_data
);

   rpd_pkg::cmd_type    cmd;
   rpd_pkg::status_type status;

   rpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rpd_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/rpd_ram.sv =====
// ---------------------------------------------------------------------------
// rpd_ram
// Generic single-clock RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module rpd_ram #(
   parameter int DATA_W = 48,
   parameter int DEPTH  = 2048,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/rpd_isqrt.sv =====
// ---------------------------------------------------------------------------
// rpd_isqrt
// Digit-by-digit integer square root, one result bit per step.
// ---------------------------------------------------------------------------
`default_nettype none

module rpd_isqrt (
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic                      step,
   input  wire logic [rpd_pkg::SUM_W-1:0] radicand,
   output logic      [rpd_pkg::ROOT_W-1:0] root
);

   localparam int CUR_W = rpd_pkg::REM_W + 2;

   logic [rpd_pkg::SUM_W-1:0]  rad_ff, rad_in;
   logic [rpd_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [rpd_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CUR_W-1:0]           cur;
   logic [CUR_W-1:0]           trial;

   always_comb begin
      cur   = {rem_ff, rad_ff[rpd_pkg::SUM_W-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (step) begin
         // bring down the next two radicand bits and try the next root bit
         rad_in = {rad_ff[rpd_pkg::SUM_W-3:0], 2'b00};
         if (cur >= trial) begin
            rem_in  = rpd_pkg::REM_W'(cur - trial);
            root_in = {root_ff[rpd_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur[rpd_pkg::REM_W-1:0];
            root_in = {root_ff[rpd_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

`default_nettype wire

// ===== src/rpd_ctrl.sv =====
// ---------------------------------------------------------------------------
// rpd_ctrl
// Sequencer: accept, square, sum, root iterations, hand off to output.
// ---------------------------------------------------------------------------
`default_nettype none

module rpd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire rpd_pkg::status_type  status,
   output rpd_pkg::cmd_type          cmd
);

   rpd_pkg::ctrl_state_type state_ff, state_in;
   logic [rpd_pkg::STEP_W-1:0] step_ff, step_in;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         rpd_pkg::ST_IDLE: begin
            if (req_valid && status.emit_item) begin
               state_in = rpd_pkg::ST_SQUARE;
            end
         end
         rpd_pkg::ST_SQUARE: begin
            state_in = rpd_pkg::ST_SUM;
         end
         rpd_pkg::ST_SUM: begin
            state_in = rpd_pkg::ST_ROOT;
            step_in  = '0;
         end
         rpd_pkg::ST_ROOT: begin
            if (step_ff == rpd_pkg::STEP_W'(rpd_pkg::SQRT_STEPS - 1)) begin
               state_in = rpd_pkg::ST_DONE;
            end
            step_in = step_ff + 1'b1;
         end
         rpd_pkg::ST_DONE: begin
            // hold until the output register is free
            if (status.out_free) begin
               state_in = rpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rpd_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         rpd_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         rpd_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
         end
         rpd_pkg::ST_SUM: begin
            cmd.load_root = 1'b1;
         end
         rpd_pkg::ST_ROOT: begin
            cmd.step_root = 1'b1;
         end
         rpd_pkg::ST_DONE: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpd_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/rpd_datapath.sv =====
// ---------------------------------------------------------------------------
// rpd_datapath
// Position counters, line buffer, squares, root units and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rpd_datapath #(
   parameter int MAX_WIDTH = rpd_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rpd_pkg::cmd_type             cmd,
   output rpd_pkg::status_type               status,
   input  wire rpd_pkg::req_type             req_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [rpd_pkg::WIDTH_W-1:0]  csr_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output rpd_pkg::rsp_type                  rsp_data
);

   localparam int DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W = (CW + 1 > rpd_pkg::WIDTH_W) ? CW + 1 : rpd_pkg::WIDTH_W;
   localparam int CH    = rpd_pkg::CHAN_W;

   logic [rpd_pkg::WIDTH_W-1:0] width_ff, width_in;
   logic [CW-1:0]               col_ff, col_in;
   logic [rpd_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [rpd_pkg::RGB_W-1:0]   left_ff, left_in;

   logic [rpd_pkg::RGB_W-1:0]   bl_ff, br_ff;
   logic [rpd_pkg::COORD_W-1:0] ocol_ff, orow_ff;
   logic [rpd_pkg::SQ_W-1:0]    sq_ff [rpd_pkg::NUM_CHAN][4];
   logic                        rsp_valid_ff, rsp_valid_in;
   rpd_pkg::rsp_type            rsp_ff;

   logic [CMP_W-1:0]            width_ext, w_eff, col_next;
   logic [CW-1:0]               col_cur;
   logic [rpd_pkg::ROW_W-1:0]   row_cur;
   logic                        wrap;
   logic [rpd_pkg::RGB_W-1:0]   rgb;
   logic [AW-1:0]               idx;
   logic                        ram_we, ram_re;
   logic [rpd_pkg::PAIR_W-1:0]  ram_rdata;
   logic [rpd_pkg::ROOT_W-1:0]  root [rpd_pkg::NUM_CHAN];
   logic [rpd_pkg::SUM_W-1:0]   sum  [rpd_pkg::NUM_CHAN];

   assign csr_ready = 1'b1;
   assign rgb       = req_data.in_pixel[rpd_pkg::RGB_W-1:0];

   // position of this pixel and of the next
   always_comb begin
      width_ext = CMP_W'(width_ff);
      if (width_ext == '0) begin
         w_eff = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ext;
      end
      col_cur  = req_data.frame_start ? '0 : col_ff;
      row_cur  = req_data.frame_start ? '0 : row_ff;
      col_next = CMP_W'(col_cur) + 1'b1;
      wrap     = (col_next >= w_eff);
      idx      = AW'(col_cur >> 1);
      status.emit_item = col_cur[0] & row_cur[0];
      status.out_free  = !rsp_valid_ff || !rsp_stall;
      ram_we = cmd.accept && col_cur[0] && !row_cur[0];
      ram_re = cmd.accept && col_cur[0] && row_cur[0];
   end

   always_comb begin
      width_in = width_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      if (csr_valid && csr_ready) begin
         width_in = csr_data;
      end
      if (cmd.accept) begin
         col_in = wrap ? '0 : CW'(col_next);
         row_in = wrap ? row_cur + 1'b1 : row_cur;
         if (!col_cur[0]) begin
            left_in = rgb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= rpd_pkg::WIDTH_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
      end else begin
         width_ff <= width_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
      end
   end

   rpd_ram #(
      .DATA_W (rpd_pkg::PAIR_W),
      .DEPTH  (DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx),
      .wr_data ({left_ff, rgb}),
      .rd_en   (ram_re),
      .rd_addr (idx),
      .rd_data (ram_rdata)
   );

   // latch the bottom pair and output position of an emitting transaction
   always_ff @(posedge clock) begin
      if (ram_re) begin
         bl_ff   <= left_ff;
         br_ff   <= rgb;
         ocol_ff <= rpd_pkg::COORD_W'(col_cur >> 1);
         orow_ff <= row_cur[rpd_pkg::ROW_W-1:1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         for (int c = 0; c < rpd_pkg::NUM_CHAN; c++) begin
            sq_ff[c][0] <= ram_rdata[rpd_pkg::RGB_W + CH*c +: CH]
                         * ram_rdata[rpd_pkg::RGB_W + CH*c +: CH];
            sq_ff[c][1] <= ram_rdata[CH*c +: CH] * ram_rdata[CH*c +: CH];
            sq_ff[c][2] <= bl_ff[CH*c +: CH] * bl_ff[CH*c +: CH];
            sq_ff[c][3] <= br_ff[CH*c +: CH] * br_ff[CH*c +: CH];
         end
      end
   end

   for (genvar c = 0; c < rpd_pkg::NUM_CHAN; c++) begin : g_chan
      assign sum[c] = rpd_pkg::SUM_W'(sq_ff[c][0]) + rpd_pkg::SUM_W'(sq_ff[c][1])
                    + rpd_pkg::SUM_W'(sq_ff[c][2]) + rpd_pkg::SUM_W'(sq_ff[c][3]);

      rpd_isqrt u_isqrt (
         .clock    (clock),
         .load     (cmd.load_root),
         .step     (cmd.step_root),
         .radicand (sum[c]),
         .root     (root[c])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // halve the root of the sum: sqrt(sum / 4)
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.out_pixel <= {rpd_pkg::ALPHA,
                              root[2][rpd_pkg::ROOT_W-1:1],
                              root[1][rpd_pkg::ROOT_W-1:1],
                              root[0][rpd_pkg::ROOT_W-1:1]};
         rsp_ff.out_col   <= ocol_ff;
         rsp_ff.out_row   <= orow_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== src/rpd_checker.sv =====
// ---------------------------------------------------------------------------
// rpd_checker
// Port-level assertions for the downsampler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rpd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire rpd_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire rpd_pkg::rsp_type rsp_data
);

   // every result carries an opaque alpha
   `RPD_ASSERT_IMPLY(a_alpha_opaque, clock, reset, rsp_valid, rsp_data.out_pixel[31:24] == rpd_pkg::ALPHA)

   // a stalled result holds
   `RPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a new result only comes out of a busy period
   `RPD_ASSERT_IMPLY(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

   // the first pixel of a frame sits at an even column and never blocks
   `RPD_ASSERT_NEXT(a_frame_start_free, clock, reset, req_valid && !req_stall && req_data.frame_start, !req_stall)

endmodule

bind rms_2x2_pixel_downsampler rpd_checker u_rpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
